[rtl/svn_pkg.sv]
// Shared types and constants of the smooth vertex normal unit.
package svn_pkg;

    localparam int IDX_W   = 12;  // vertex index field
    localparam int NORM_W  = 18;  // Q1.16 normal component
    localparam int SUM_W   = 26;  // per-vertex normal sum component
    localparam int FRAC_W  = 16;  // fraction bits of a normal
    localparam int LIM_BIT = 30;  // vectors are scaled below 2^LIM_BIT
    localparam int MAG_W   = 62;  // magnitude register width
    localparam int CX_W    = 63;  // signed cross product component
    localparam int LEN_W   = 32;  // vector length
    localparam int Q_W     = FRAC_W + 1;
    localparam int NUM_W   = LIM_BIT + FRAC_W + 1;

    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(33554431);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(33554432);

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_UNLOADED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

[rtl/svn_if.sv]
// Item and result channel interfaces of the smooth vertex normal unit.
interface svn_item_if import svn_pkg::*; #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [IDX_W-1:0]             idx_a;
    logic [IDX_W-1:0]             idx_b;
    logic [IDX_W-1:0]             idx_c;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, idx_a, idx_b, idx_c,
                    input ready);
    modport sink (input valid, cmd, pos_x, pos_y, pos_z, idx_a, idx_b, idx_c,
                  output ready);
endinterface

interface svn_result_if import svn_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [1:0]               status;

    modport source (output valid, norm_x, norm_y, norm_z, status, input ready);
    modport sink (input valid, norm_x, norm_y, norm_z, status, output ready);
endinterface

[rtl/smooth_vertex_normal_unit.sv]
// Smooth vertex normal unit: vertex table, face normals and per-vertex smoothed normals.
//
// Each item is taken while ready is high and answered by exactly one result beat;
// the unit works on one item at a time and holds ready low until the result has
// been taken. A store, an unused command or a bad index goes straight to the result
// beat. A query reads the sums of its vertex; a triangle reads its three corners and
// forms the cross product of the coordinate differences. Each vector is scaled below
// 2^30, and a zero vector ends in a zero status; else the length and the three
// components are worked out, and a triangle then adds its normal to the corner sums.
// With 24-bit coordinates the differences need no shift and the cross product is
// shifted by at most 19 bits. The next item can be taken in the cycle after the result.
// The work is done by the shared sequencer: one 30x30
// multiplier for the six cross product terms and three squares, a one-bit-a-cycle
// scaling shifter, a 31-step square root and a 17-step restoring divider run once
// per component, and for a triangle three read-modify-write passes over the sum
// memory. Sums need no clearing pass after reset: a store writes zero to the sums
// of the slot it fills, and only filled slots are ever read. Positions and sums
// live in two RAMs of VERTS entries.
module smooth_vertex_normal_unit import svn_pkg::*; #(
    parameter int VERTS      = 4096,
    parameter int COORD_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    svn_item_if.sink     item,
    svn_result_if.source result
);
    localparam int AW = $clog2(VERTS);
    localparam int CW = AW + 1;
    localparam int VW = 3 * COORD_BITS;
    localparam int SW = 3 * SUM_W;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * LIM_BIT;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_FIT  = 10'b0000000100,
        S_MUL  = 10'b0000001000,
        S_CLD  = 10'b0000010000,
        S_SQ   = 10'b0000100000,
        S_SQRT = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_UPD  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    // control
    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] ia_reg, ia_next, ib_reg, ib_next, ic_reg, ic_next;
    logic [4:0]       step_reg, step_next;
    logic [1:0]       comp_reg, comp_next;
    logic             phase_reg, phase_next;

    // datapath
    logic [VW-1:0]           pa_reg, pa_next;
    logic [MAG_W-1:0]        mag_reg [6];
    logic [MAG_W-1:0]        mag_next [6];
    logic                    neg_reg [6];
    logic                    neg_next [6];
    logic [PW-1:0]           prod_reg, prod_next;
    logic                    pneg_reg, pneg_next;
    logic [1:0]              ptgt_reg, ptgt_next;
    logic signed [CX_W-1:0]  c_reg [3];
    logic signed [CX_W-1:0]  c_next [3];
    logic [MAG_W-1:0]        sq_reg, sq_next;
    logic [MAG_W-1:0]        rem_reg, rem_next;
    logic [MAG_W-1:0]        root_reg, root_next;
    logic [MAG_W-1:0]        bit_reg, bit_next;
    logic [Q_W-1:0]          nbits_reg, nbits_next;
    logic [Q_W-1:0]          q_reg, q_next;
    logic signed [NORM_W-1:0] nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    status_t                 status_reg, status_next;

    // memories
    logic          vert_we;
    logic [AW-1:0] vert_waddr, vert_raddr;
    logic [VW-1:0] vert_wdata, vert_rdata;
    logic          sum_we;
    logic [AW-1:0] sum_waddr, sum_raddr;
    logic [SW-1:0] sum_wdata, sum_rdata;

    // helpers
    logic             accept;
    logic             full;
    logic [2:0]       sel_a, sel_b;
    logic [1:0]       mul_tgt;
    logic             mul_sub;
    logic [LIM_BIT-1:0] mul_a, mul_b;
    logic [PW-1:0]    mul_p;
    logic             big;
    logic signed [CX_W-1:0] prod_s;
    logic [MAG_W-1:0] sqrt_try;
    logic [LEN_W-1:0] len;
    logic [MAG_W-1:0] dmag;
    logic             dneg;
    logic [NUM_W-1:0] div_num;
    logic [LEN_W:0]   div_t;
    logic             div_ge;
    logic [LEN_W:0]   div_rem;
    logic [Q_W-1:0]   q_new;
    logic signed [NORM_W-1:0] q_signed;
    logic [IDX_W-1:0] corner;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W+AW-1:0] e;
        e = {{AW{1'b0}}, idx};
        return e[AW-1:0];
    endfunction

    function automatic logic is_loaded(input logic [IDX_W-1:0] idx,
                                       input logic [CW-1:0] cnt);
        return (idx != '0) && ({{CW{1'b0}}, idx} < {{IDX_W{1'b0}}, cnt});
    endfunction

    function automatic logic [MAG_W-1:0] diff_mag(input logic [COORD_BITS-1:0] b,
                                                  input logic [COORD_BITS-1:0] a,
                                                  output logic neg);
        logic signed [DW-1:0] d;
        logic [DW-1:0]        m;
        d   = $signed({b[COORD_BITS-1], b}) - $signed({a[COORD_BITS-1], a});
        neg = d[DW-1];
        m   = d[DW-1] ? DW'(-d) : DW'(d);
        return {{(MAG_W-DW){1'b0}}, m};
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [NORM_W-1:0] b);
        logic signed [SUM_W:0] r;
        r = $signed({a[SUM_W-1], a}) +
            $signed({{(SUM_W+1-NORM_W){b[NORM_W-1]}}, b});
        if (r > SUM_MAX)
        begin
            r = SUM_MAX;
        end
        if (r < SUM_MIN)
        begin
            r = SUM_MIN;
        end
        return r[SUM_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] sum_mag(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] m;
        m = s[SUM_W-1] ? (~s + 1'b1) : s;
        return {{(MAG_W-SUM_W){1'b0}}, m};
    endfunction

    svn_ram #(.WIDTH(VW), .DEPTH(VERTS)) u_vert_ram (
        .clk   (clk),
        .we    (vert_we),
        .waddr (vert_waddr),
        .wdata (vert_wdata),
        .raddr (vert_raddr),
        .rdata (vert_rdata)
    );

    svn_ram #(.WIDTH(SW), .DEPTH(VERTS)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    assign item.ready    = (state_reg == S_IDLE);
    assign accept        = item.valid && item.ready;
    assign full          = (count_reg == CW'(VERTS));
    assign result.valid  = (state_reg == S_OUT);
    assign result.norm_x = nx_reg;
    assign result.norm_y = ny_reg;
    assign result.norm_z = nz_reg;
    assign result.status = status_reg;

    // cross product term schedule: c[tgt] +/-= d[a] * d[b]
    always_comb
    begin
        sel_a   = 3'd1;
        sel_b   = 3'd5;
        mul_tgt = 2'd0;
        mul_sub = 1'b0;
        case (step_reg[2:0])
            3'd0:    begin sel_a = 3'd1; sel_b = 3'd5; mul_tgt = 2'd0; mul_sub = 1'b0; end
            3'd1:    begin sel_a = 3'd2; sel_b = 3'd4; mul_tgt = 2'd0; mul_sub = 1'b1; end
            3'd2:    begin sel_a = 3'd2; sel_b = 3'd3; mul_tgt = 2'd1; mul_sub = 1'b0; end
            3'd3:    begin sel_a = 3'd0; sel_b = 3'd5; mul_tgt = 2'd1; mul_sub = 1'b1; end
            3'd4:    begin sel_a = 3'd0; sel_b = 3'd4; mul_tgt = 2'd2; mul_sub = 1'b0; end
            3'd5:    begin sel_a = 3'd1; sel_b = 3'd3; mul_tgt = 2'd2; mul_sub = 1'b1; end
            default: begin sel_a = 3'd0; sel_b = 3'd0; mul_tgt = 2'd0; mul_sub = 1'b0; end
        endcase
        // squares reuse the same operand on both sides
        if (state_reg == S_SQ)
        begin
            sel_a = {1'b0, step_reg[1:0]};
            sel_b = {1'b0, step_reg[1:0]};
        end
    end

    always_comb
    begin
        mul_a = '0;
        case (sel_a)
            3'd0:    mul_a = mag_reg[0][LIM_BIT-1:0];
            3'd1:    mul_a = mag_reg[1][LIM_BIT-1:0];
            3'd2:    mul_a = mag_reg[2][LIM_BIT-1:0];
            3'd3:    mul_a = mag_reg[3][LIM_BIT-1:0];
            3'd4:    mul_a = mag_reg[4][LIM_BIT-1:0];
            3'd5:    mul_a = mag_reg[5][LIM_BIT-1:0];
            default: mul_a = '0;
        endcase
        mul_b = '0;
        case (sel_b)
            3'd0:    mul_b = mag_reg[0][LIM_BIT-1:0];
            3'd1:    mul_b = mag_reg[1][LIM_BIT-1:0];
            3'd2:    mul_b = mag_reg[2][LIM_BIT-1:0];
            3'd3:    mul_b = mag_reg[3][LIM_BIT-1:0];
            3'd4:    mul_b = mag_reg[4][LIM_BIT-1:0];
            3'd5:    mul_b = mag_reg[5][LIM_BIT-1:0];
            default: mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // the one component under division
    always_comb
    begin
        dmag = mag_reg[0];
        dneg = neg_reg[0];
        case (comp_reg)
            2'd0:    begin dmag = mag_reg[0]; dneg = neg_reg[0]; end
            2'd1:    begin dmag = mag_reg[1]; dneg = neg_reg[1]; end
            2'd2:    begin dmag = mag_reg[2]; dneg = neg_reg[2]; end
            default: begin dmag = mag_reg[0]; dneg = neg_reg[0]; end
        endcase
        corner = ia_reg;
        case (comp_reg)
            2'd0:    corner = ia_reg;
            2'd1:    corner = ib_reg;
            2'd2:    corner = ic_reg;
            default: corner = ia_reg;
        endcase
    end

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            if (mag_reg[i][MAG_W-1:LIM_BIT] != '0)
            begin
                big = 1'b1;
            end
        end
    end

    assign prod_s   = pneg_reg ? -$signed({{(CX_W-PW){1'b0}}, prod_reg})
                               :  $signed({{(CX_W-PW){1'b0}}, prod_reg});
    assign sqrt_try = root_reg + bit_reg;
    assign len      = root_reg[LEN_W-1:0];
    assign div_num  = {1'b0, dmag[LIM_BIT-1:0], {FRAC_W{1'b0}}} +
                      {{(NUM_W-LEN_W){1'b0}}, 1'b0, len[LEN_W-1:1]};
    assign div_t    = {rem_reg[LEN_W-1:0], nbits_reg[Q_W-1]};
    assign div_ge   = (div_t >= {1'b0, len});
    assign div_rem  = div_ge ? (div_t - {1'b0, len}) : div_t;
    assign q_new    = {q_reg[Q_W-2:0], div_ge};
    assign q_signed = dneg ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});

    // memory ports
    always_comb
    begin
        vert_we    = accept && (cmd_t'(item.cmd) == CMD_STORE) && !full;
        vert_waddr = count_reg[AW-1:0];
        vert_wdata = {item.pos_x, item.pos_y, item.pos_z};
        vert_raddr = to_addr(ia_reg);
        case (step_reg[1:0])
            2'd1:    vert_raddr = to_addr(ib_reg);
            2'd2:    vert_raddr = to_addr(ic_reg);
            default: vert_raddr = to_addr(ia_reg);
        endcase

        sum_raddr = (state_reg == S_UPD) ? to_addr(corner) : to_addr(ia_reg);
        if (state_reg == S_UPD)
        begin
            sum_we    = (step_reg[0] == 1'b1);
            sum_waddr = to_addr(corner);
            sum_wdata = {sat_add(sum_rdata[SW-1 -: SUM_W], nx_reg),
                         sat_add(sum_rdata[SW-SUM_W-1 -: SUM_W], ny_reg),
                         sat_add(sum_rdata[SUM_W-1:0], nz_reg)};
        end
        else
        begin
            // a newly filled slot starts with cleared sums
            sum_we    = vert_we;
            sum_waddr = count_reg[AW-1:0];
            sum_wdata = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        ia_next     = ia_reg;
        ib_next     = ib_reg;
        ic_next     = ic_reg;
        step_next   = step_reg;
        comp_next   = comp_reg;
        phase_next  = phase_reg;
        pa_next     = pa_reg;
        prod_next   = prod_reg;
        pneg_next   = pneg_reg;
        ptgt_next   = ptgt_reg;
        sq_next     = sq_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        nbits_next  = nbits_reg;
        q_next      = q_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        nz_next     = nz_reg;
        status_next = status_reg;
        for (int i = 0; i < 6; i++)
        begin
            mag_next[i] = mag_reg[i];
            neg_next[i] = neg_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            c_next[i] = c_reg[i];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd_t'(item.cmd);
                    ia_next     = item.idx_a;
                    ib_next     = item.idx_b;
                    ic_next     = item.idx_c;
                    nx_next     = '0;
                    ny_next     = '0;
                    nz_next     = '0;
                    status_next = ST_OK;
                    step_next   = '0;
                    state_next  = S_OUT;
                    case (cmd_t'(item.cmd))
                        CMD_STORE:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_TRI:
                        begin
                            if (is_loaded(item.idx_a, count_reg) &&
                                is_loaded(item.idx_b, count_reg) &&
                                is_loaded(item.idx_c, count_reg))
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                status_next = ST_UNLOADED;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (is_loaded(item.idx_a, count_reg))
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                status_next = ST_UNLOADED;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                step_next = step_reg + 1'b1;
                if (cmd_reg == CMD_QUERY)
                begin
                    if (step_reg == 5'd1)
                    begin
                        mag_next[0] = sum_mag(sum_rdata[SW-1 -: SUM_W]);
                        neg_next[0] = sum_rdata[SW-1];
                        mag_next[1] = sum_mag(sum_rdata[SW-SUM_W-1 -: SUM_W]);
                        neg_next[1] = sum_rdata[SW-SUM_W-1];
                        mag_next[2] = sum_mag(sum_rdata[SUM_W-1:0]);
                        neg_next[2] = sum_rdata[SUM_W-1];
                        for (int i = 3; i < 6; i++)
                        begin
                            mag_next[i] = '0;
                            neg_next[i] = 1'b0;
                        end
                        phase_next = 1'b1;
                        state_next = S_FIT;
                    end
                end
                else
                begin
                    case (step_reg[1:0])
                        2'd1: pa_next = vert_rdata;
                        2'd2:
                        begin
                            mag_next[0] = diff_mag(vert_rdata[VW-1 -: COORD_BITS],
                                                   pa_reg[VW-1 -: COORD_BITS], neg_next[0]);
                            mag_next[1] = diff_mag(vert_rdata[VW-COORD_BITS-1 -: COORD_BITS],
                                                   pa_reg[VW-COORD_BITS-1 -: COORD_BITS],
                                                   neg_next[1]);
                            mag_next[2] = diff_mag(vert_rdata[COORD_BITS-1:0],
                                                   pa_reg[COORD_BITS-1:0], neg_next[2]);
                        end
                        2'd3:
                        begin
                            mag_next[3] = diff_mag(vert_rdata[VW-1 -: COORD_BITS],
                                                   pa_reg[VW-1 -: COORD_BITS], neg_next[3]);
                            mag_next[4] = diff_mag(vert_rdata[VW-COORD_BITS-1 -: COORD_BITS],
                                                   pa_reg[VW-COORD_BITS-1 -: COORD_BITS],
                                                   neg_next[4]);
                            mag_next[5] = diff_mag(vert_rdata[COORD_BITS-1:0],
                                                   pa_reg[COORD_BITS-1:0], neg_next[5]);
                            phase_next  = 1'b0;
                            state_next  = S_FIT;
                        end
                        default: pa_next = pa_reg;
                    endcase
                end
            end

            S_FIT:
            begin
                // one bit a cycle until every magnitude is below 2^30
                if (big)
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (!phase_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        c_next[i] = '0;
                    end
                    step_next  = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    sq_next    = '0;
                    step_next  = '0;
                    state_next = S_SQ;
                end
            end

            S_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg < 5'd6)
                begin
                    prod_next = mul_p;
                    pneg_next = neg_reg[sel_a] ^ neg_reg[sel_b] ^ mul_sub;
                    ptgt_next = mul_tgt;
                end
                if (step_reg != 5'd0)
                begin
                    c_next[ptgt_reg] = c_reg[ptgt_reg] + prod_s;
                end
                if (step_reg == 5'd6)
                begin
                    state_next = S_CLD;
                end
            end

            S_CLD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_next[i]     = c_reg[i][CX_W-1] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
                    neg_next[i]     = c_reg[i][CX_W-1];
                    mag_next[i + 3] = '0;
                    neg_next[i + 3] = 1'b0;
                end
                phase_next = 1'b1;
                state_next = S_FIT;
            end

            S_SQ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg < 5'd3)
                begin
                    prod_next = mul_p;
                end
                if (step_reg != 5'd0)
                begin
                    sq_next = sq_reg + {{(MAG_W-PW){1'b0}}, prod_reg};
                end
                if (step_reg == 5'd3)
                begin
                    if (sq_next == '0)
                    begin
                        status_next = ST_ZERO;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        rem_next   = sq_next;
                        root_next  = '0;
                        bit_next   = MAG_W'(1) << 60;
                        state_next = S_SQRT;
                    end
                end
            end

            S_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    comp_next  = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    if (rem_reg >= sqrt_try)
                    begin
                        rem_next  = rem_reg - sqrt_try;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end

            S_DIV:
            begin
                if (step_reg == 5'd0)
                begin
                    rem_next   = {{(MAG_W-NUM_W+Q_W){1'b0}}, div_num[NUM_W-1:Q_W]};
                    nbits_next = div_num[Q_W-1:0];
                    q_next     = '0;
                    step_next  = 5'd1;
                end
                else
                begin
                    rem_next   = {{(MAG_W-LEN_W-1){1'b0}}, div_rem};
                    nbits_next = {nbits_reg[Q_W-2:0], 1'b0};
                    q_next     = q_new;
                    step_next  = step_reg + 1'b1;
                    if (step_reg == 5'(Q_W))
                    begin
                        case (comp_reg)
                            2'd0:    nx_next = q_signed;
                            2'd1:    ny_next = q_signed;
                            default: nz_next = q_signed;
                        endcase
                        step_next = '0;
                        if (comp_reg == 2'd2)
                        begin
                            comp_next  = '0;
                            state_next = (cmd_reg == CMD_TRI) ? S_UPD : S_OUT;
                        end
                        else
                        begin
                            comp_next = comp_reg + 1'b1;
                        end
                    end
                end
            end

            S_UPD:
            begin
                // read a corner's sums, then write them back with the face normal added
                step_next = {4'd0, ~step_reg[0]};
                if (step_reg[0])
                begin
                    if (comp_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        comp_next = comp_reg + 1'b1;
                    end
                end
            end

            S_OUT:
            begin
                if (result.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            step_reg  <= '0;
            comp_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ia_reg     <= ia_next;
        ib_reg     <= ib_next;
        ic_reg     <= ic_next;
        pa_reg     <= pa_next;
        prod_reg   <= prod_next;
        pneg_reg   <= pneg_next;
        ptgt_reg   <= ptgt_next;
        sq_reg     <= sq_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        nbits_reg  <= nbits_next;
        q_reg      <= q_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        nz_reg     <= nz_next;
        status_reg <= status_next;
        for (int i = 0; i < 6; i++)
        begin
            mag_reg[i] <= mag_next[i];
            neg_reg[i] <= neg_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            c_reg[i] <= c_next[i];
        end
    end
endmodule

[rtl/svn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module svn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[test/smooth_vertex_normal_unit_tb.sv]
// Self-checking testbench of the smooth vertex normal unit.
`timescale 1ns / 1ps

module smooth_vertex_normal_unit_tb;
    import svn_pkg::*;

    localparam int VERTS      = 4096;
    localparam int COORD_BITS = 24;
    localparam int STALL_LIMIT = 4000;

    localparam logic signed [COORD_BITS-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_BITS-1:0] POS_MIN = 24'sh800000;

    typedef struct {
        cmd_t                         cmd;
        logic signed [COORD_BITS-1:0] px, py, pz;
        logic [IDX_W-1:0]             ia, ib, ic;
    } beat_t;

    typedef struct {
        logic [NORM_W-1:0] nx, ny, nz;
        status_t           st;
    } normal_t;

    // Tracks the vertex table and sums, and holds the normals still owed.
    class normal_board;
        longint  pos_x[VERTS], pos_y[VERTS], pos_z[VERTS];
        longint  acc_x[VERTS], acc_y[VERTS], acc_z[VERTS];
        int      fill;
        normal_t owed[$];
        int      errors, checked, stores, tris, queries, full_hits, sat_hits;

        function new();
            for (int i = 0; i < VERTS; i++)
            begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
                acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
            end
            fill = 1;
        endfunction

        static function longint unsigned magn(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        static function longint shr_keep_sign(longint v, int s);
            longint unsigned m;
            m = magn(v) >> s;
            return v < 0 ? -longint'(m) : longint'(m);
        endfunction

        // smallest right shift that brings a magnitude below 2^30
        static function int fit_shift(longint unsigned mx);
            int s;
            s = 0;
            while ((mx >> s) >= (64'd1 << LIM_BIT))
                s++;
            return s;
        endfunction

        static function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // normalise to Q1.16; return 0 for a zero vector
        static function bit to_unit(input longint c[3], output longint n[3]);
            longint          v[3];
            longint unsigned mx, sq, len, q;
            int              s;
            mx = 0;
            sq = 0;
            for (int i = 0; i < 3; i++)
                if (magn(c[i]) > mx)
                    mx = magn(c[i]);
            s = fit_shift(mx);
            for (int i = 0; i < 3; i++)
            begin
                v[i] = shr_keep_sign(c[i], s);
                sq += magn(v[i]) * magn(v[i]);
                n[i] = 0;
            end
            if (sq == 0)
                return 0;
            len = root(sq);
            for (int i = 0; i < 3; i++)
            begin
                q = ((magn(v[i]) << FRAC_W) + (len >> 1)) / len;
                n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function longint sat(longint a, longint b);
            longint r;
            r = a + b;
            if (r > SUM_MAX || r < SUM_MIN)
                sat_hits++;
            if (r > SUM_MAX)
                r = SUM_MAX;
            if (r < SUM_MIN)
                r = SUM_MIN;
            return r;
        endfunction

        function bit loaded(int i);
            return i != 0 && i < fill;
        endfunction

        // Work out the normal that an accepted item must produce.
        function void note(beat_t b);
            longint  n[3], c[3], d[6];
            longint unsigned mx;
            int      s, k[3];
            status_t st;
            normal_t e;
            n = '{0, 0, 0};
            st = ST_OK;
            case (b.cmd)
                CMD_STORE:
                begin
                    stores++;
                    if (fill >= VERTS)
                    begin
                        st = ST_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        pos_x[fill] = b.px; pos_y[fill] = b.py; pos_z[fill] = b.pz;
                        acc_x[fill] = 0; acc_y[fill] = 0; acc_z[fill] = 0;
                        fill++;
                    end
                end
                CMD_TRI:
                begin
                    tris++;
                    k = '{b.ia, b.ib, b.ic};
                    if (!loaded(k[0]) || !loaded(k[1]) || !loaded(k[2]))
                        st = ST_UNLOADED;
                    else
                    begin
                        d[0] = pos_x[k[1]] - pos_x[k[0]];
                        d[1] = pos_y[k[1]] - pos_y[k[0]];
                        d[2] = pos_z[k[1]] - pos_z[k[0]];
                        d[3] = pos_x[k[2]] - pos_x[k[0]];
                        d[4] = pos_y[k[2]] - pos_y[k[0]];
                        d[5] = pos_z[k[2]] - pos_z[k[0]];
                        mx = 0;
                        for (int i = 0; i < 6; i++)
                            if (magn(d[i]) > mx)
                                mx = magn(d[i]);
                        s = fit_shift(mx);
                        for (int i = 0; i < 6; i++)
                            d[i] = shr_keep_sign(d[i], s);
                        c[0] = d[1] * d[5] - d[2] * d[4];
                        c[1] = d[2] * d[3] - d[0] * d[5];
                        c[2] = d[0] * d[4] - d[1] * d[3];
                        if (!to_unit(c, n))
                            st = ST_ZERO;
                        else
                            for (int i = 0; i < 3; i++)
                            begin
                                acc_x[k[i]] = sat(acc_x[k[i]], n[0]);
                                acc_y[k[i]] = sat(acc_y[k[i]], n[1]);
                                acc_z[k[i]] = sat(acc_z[k[i]], n[2]);
                            end
                    end
                end
                CMD_QUERY:
                begin
                    queries++;
                    if (!loaded(b.ia))
                        st = ST_UNLOADED;
                    else
                    begin
                        c = '{acc_x[b.ia], acc_y[b.ia], acc_z[b.ia]};
                        if (!to_unit(c, n))
                            st = ST_ZERO;
                    end
                end
                default: ;
            endcase
            e.nx = NORM_W'(n[0]);
            e.ny = NORM_W'(n[1]);
            e.nz = NORM_W'(n[2]);
            e.st = st;
            owed = {owed, e};
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check(normal_t r);
            normal_t e;
            if (owed.size() == 0)
            begin
                report("result beat with nothing outstanding");
                return;
            end
            e = owed.pop_front();
            checked++;
            if (r.nx !== e.nx)
                report($sformatf("norm_x %h, want %h", r.nx, e.nx));
            if (r.ny !== e.ny)
                report($sformatf("norm_y %h, want %h", r.ny, e.ny));
            if (r.nz !== e.nz)
                report($sformatf("norm_z %h, want %h", r.nz, e.nz));
            if (r.st !== e.st)
                report($sformatf("status %s, want %s", r.st.name(), e.st.name()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    svn_item_if #(.COORD_BITS(COORD_BITS)) item ();
    svn_result_if result ();

    smooth_vertex_normal_unit #(.VERTS(VERTS), .COORD_BITS(COORD_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    normal_board board;
    int          send_idle;   // percent of cycles the sender holds off
    int          take_idle;   // percent of cycles the receiver stalls
    int          quiet;       // cycles since the last accepted beat

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: drop ready at random according to the current stall rate.
    always @(posedge clk)
        result.ready <= rst_n && ($urandom_range(99) >= take_idle);

    // Monitor: note every accepted item beat and check every result beat.
    always @(posedge clk)
    begin
        beat_t   b;
        normal_t r;
        if (rst_n)
        begin
            if (item.valid && item.ready)
            begin
                b.cmd = cmd_t'(item.cmd);
                b.px = item.pos_x; b.py = item.pos_y; b.pz = item.pos_z;
                b.ia = item.idx_a; b.ib = item.idx_b; b.ic = item.idx_c;
                board.note(b);
            end
            if (result.valid && result.ready)
            begin
                r.nx = result.norm_x; r.ny = result.norm_y; r.nz = result.norm_z;
                r.st = status_t'(result.status);
                board.check(r);
            end
        end
    end

    // Watchdog: give up when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("smooth_vertex_normal_unit_tb failed");
            $finish;
        end
    end

    // Drive one item beat, idling first at random; hold it until accepted.
    task send(cmd_t cmd, logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
              logic signed [COORD_BITS-1:0] z, int a, int b, int c);
        while ($urandom_range(99) < send_idle)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.cmd   <= cmd;
        item.pos_x <= x; item.pos_y <= y; item.pos_z <= z;
        item.idx_a <= IDX_W'(a); item.idx_b <= IDX_W'(b); item.idx_c <= IDX_W'(c);
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    task store(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
               logic signed [COORD_BITS-1:0] z);
        send(CMD_STORE, x, y, z, $urandom, $urandom, $urandom);
    endtask

    task face(int a, int b, int c);
        send(CMD_TRI, 24'($urandom), 24'($urandom), 24'($urandom), a, b, c);
    endtask

    task query(int a);
        send(CMD_QUERY, 24'($urandom), 24'($urandom), 24'($urandom), a, $urandom, $urandom);
    endtask

    // Hold the sender until every owed result has come back.
    task drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0)
            @(posedge clk);
    endtask

    // Coordinate of random magnitude, so the scaling shift varies widely.
    function automatic logic signed [COORD_BITS-1:0] any_coord();
        logic signed [COORD_BITS-1:0] t;
        int w;
        w = $urandom_range(1, COORD_BITS);
        t = COORD_BITS'($urandom);
        t = t <<< (COORD_BITS - w);
        return t >>> (COORD_BITS - w);
    endfunction

    // Mostly a loaded index, sometimes anything at all.
    function automatic int pick_index();
        if ($urandom_range(19) == 0 || board.fill < 2)
            return $urandom_range(VERTS - 1);
        return $urandom_range(1, board.fill - 1);
    endfunction

    task random_items(int count);
        int op;
        for (int i = 0; i < count; i++)
        begin
            op = $urandom_range(99);
            if (op < 25)
                store(any_coord(), any_coord(), any_coord());
            else if (op < 70)
                face(pick_index(), pick_index(), pick_index());
            else if (op < 95)
                query(pick_index());
            else
                send(cmd_t'($urandom_range(3)), 24'($urandom), 24'($urandom),
                     24'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        board = new();
        send_idle = 0;
        take_idle = 0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.cmd = CMD_NONE;
        item.pos_x = '0; item.pos_y = '0; item.pos_z = '0;
        item.idx_a = '0; item.idx_b = '0; item.idx_c = '0;
        result.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, corner coordinates, degenerate faces, zero sums.
        send_idle = 24; take_idle = 61;
        query(0);
        face(1, 2, 3);
        send(CMD_NONE, POS_MAX, POS_MIN, POS_MAX, 4095, 4095, 4095);
        store(POS_MIN, POS_MIN, POS_MIN);
        store(POS_MAX, POS_MIN, POS_MIN);
        store(POS_MIN, POS_MAX, POS_MIN);
        store(POS_MIN, POS_MIN, POS_MAX);
        store(24'sd0, 24'sd0, 24'sd0);
        store(24'sd2, 24'sd2, 24'sd2);
        store(24'sd4, 24'sd4, 24'sd4);
        store(POS_MAX, POS_MAX, POS_MAX);
        face(1, 2, 3);
        face(1, 3, 4);
        face(1, 1, 2);
        face(5, 6, 7);
        face(1, 2, 9);
        face(0, 1, 2);
        query(1);
        query(5);
        query(9);
        face(2, 4, 8);
        query(8);
        query(0);

        // Random traffic under three idling patterns, with a full drain between.
        random_items(50);
        drain();
        send_idle = 61; take_idle = 24;
        random_items(50);
        drain();
        send_idle = 0; take_idle = 0;
        random_items(50);

        // Saturate the z sums of vertices 1, 2 and 3 upwards.
        for (int i = 0; i < 530; i++)
            face(1, 2, 3);
        query(1);
        query(2);

        // Indices at the top of the range are never loaded.
        query(VERTS - 1);
        face(VERTS - 1, 2730, 1365);

        item.valid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d stores (%0d on a full table), %0d triangles, %0d queries",
                 board.stores, board.full_hits, board.tris, board.queries);
        $display("%0d results checked, %0d saturating additions, %0d mismatches",
                 board.checked, board.sat_hits, board.errors);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("smooth_vertex_normal_unit_tb passed");
        else
            $display("smooth_vertex_normal_unit_tb failed");
        $finish;
    end

endmodule
